// ===== hdl/lphash_pkg.sv =====
// shared types, constants and helpers of the linear probing hash table
`default_nettype none
package lphash_pkg;

    localparam int CAPACITY = 128;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int COLL_W   = 32;

    localparam logic [KEY_W-1:0] MIX_MUL   = 32'h045d_9f3b;
    localparam int               MIX_SHIFT = 16;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_FIND   = 2'd1,
        MODE_ERASE  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_ERASED    = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    load;        // take a new request
        logic    hash0;       // first mix round
        logic    hash1;       // second mix round
        logic    hash2;       // final fold, start probing
        logic    cl_addr;     // ram read at cluster pointer
        logic    coll_inc;
        logic    put_new;     // write entry into a free slot
        logic    put_upd;     // overwrite value of matching key
        logic    adv;         // step probe pointer
        logic    erase_at_p;  // free slot under probe, start cluster walk
        logic    cl_load;     // lift cluster entry out for reinsertion
        logic    cl_adv;      // step cluster pointer
        logic    res_wr;
        status_t res_status;
        logic    res_slot;    // report probe slot, else 0
        logic    res_val;     // report stored value, else 0
        logic    out_load;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        mode_t mode;
        logic  occ_p;
        logic  occ_cs;
        logic  key_eq;
        logic  first;
        logic  n_last;
        logic  cn_last;
    } dp_stat_t;

    function automatic logic [KEY_W-1:0] mix_fold(input logic [KEY_W-1:0] x);
        return (x >> MIX_SHIFT) ^ x;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/lphash_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module lphash_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/lphash_datapath.sv =====
// datapath: request registers, key mix, probe pointers, occupancy and table ram
`default_nettype none
module lphash_datapath (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire lphash_pkg::dp_cmd_t      cmd,
    output lphash_pkg::dp_stat_t          stat,
    input  wire logic [1:0]               s_mode,
    input  wire logic [31:0]              s_key,
    input  wire logic [31:0]              s_value,
    output logic [2:0]                    m_status,
    output logic [6:0]                    m_slot,
    output logic [31:0]                   m_value_out,
    output logic [lphash_pkg::CNT_W-1:0]  m_count,
    output logic [31:0]                   m_collisions
);
    import lphash_pkg::*;

    mode_t              mode_reg;
    logic [KEY_W-1:0]   ckey_reg;
    logic [VAL_W-1:0]   cval_reg;
    logic [KEY_W-1:0]   m1_reg;
    logic [KEY_W-1:0]   m2_reg;
    logic [SLOT_W-1:0]  p_reg;
    logic [SLOT_W-1:0]  cs_reg;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   cn_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [COLL_W-1:0]  coll_reg;
    logic               occ_reg [CAPACITY];
    status_t            status_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [VAL_W-1:0]   vout_reg;

    logic [KEY_W-1:0]   fold2;
    logic [SLOT_W-1:0]  home;
    logic [SLOT_W-1:0]  p_inc;
    logic [SLOT_W-1:0]  cs_inc;
    logic [SLOT_W-1:0]  raddr;
    logic [KEY_W+VAL_W-1:0] rdata;

    assign fold2 = mix_fold(m2_reg);
    // capacity is a power of two: modulo is the low bits
    assign home  = fold2[SLOT_W-1:0];
    assign p_inc  = (p_reg == SLOT_W'(CAPACITY - 1)) ? '0 : p_reg + 1'b1;
    assign cs_inc = (cs_reg == SLOT_W'(CAPACITY - 1)) ? '0 : cs_reg + 1'b1;
    assign raddr  = cmd.cl_addr ? cs_reg : p_reg;

    lphash_ram #(.WIDTH(KEY_W + VAL_W), .DEPTH(CAPACITY)) u_table (
        .aclk  (aclk),
        .we    (cmd.put_new | cmd.put_upd),
        .waddr (p_reg),
        .wdata ({ckey_reg, cval_reg}),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign stat.mode    = mode_reg;
    assign stat.occ_p   = occ_reg[p_reg];
    assign stat.occ_cs  = occ_reg[cs_reg];
    assign stat.key_eq  = (rdata[KEY_W+VAL_W-1:VAL_W] == ckey_reg);
    assign stat.first   = (n_reg == '0);
    assign stat.n_last  = (n_reg == CNT_W'(CAPACITY - 1));
    assign stat.cn_last = (cn_reg == CNT_W'(CAPACITY - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg <= mode_t'(s_mode);
            ckey_reg <= s_key;
            cval_reg <= s_value;
        end else if (cmd.cl_load) begin
            ckey_reg <= rdata[KEY_W+VAL_W-1:VAL_W];
            cval_reg <= rdata[VAL_W-1:0];
        end
        if (cmd.hash0) begin
            m1_reg <= KEY_W'(mix_fold(ckey_reg) * MIX_MUL);
        end
        if (cmd.hash1) begin
            m2_reg <= KEY_W'(mix_fold(m1_reg) * MIX_MUL);
        end
        if (cmd.hash2) begin
            p_reg <= home;
            n_reg <= '0;
        end else if (cmd.adv) begin
            p_reg <= p_inc;
            n_reg <= n_reg + 1'b1;
        end
        if (cmd.erase_at_p) begin
            cs_reg <= p_inc;
            cn_reg <= '0;
        end else if (cmd.cl_adv) begin
            cs_reg <= cs_inc;
            cn_reg <= cn_reg + 1'b1;
        end
        if (cmd.load) begin
            status_reg <= ST_NOT_FOUND;
            slot_reg   <= '0;
            vout_reg   <= '0;
        end else if (cmd.res_wr) begin
            status_reg <= cmd.res_status;
            slot_reg   <= cmd.res_slot ? p_reg : '0;
            vout_reg   <= cmd.res_val ? rdata[VAL_W-1:0] : '0;
        end
        if (cmd.out_load) begin
            m_status     <= status_reg;
            m_slot       <= 7'(slot_reg);
            m_value_out  <= vout_reg;
            m_count      <= count_reg;
            m_collisions <= coll_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            coll_reg  <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                occ_reg[i] <= 1'b0;
            end
        end else begin
            if (cmd.coll_inc && coll_reg != '1) begin
                coll_reg <= coll_reg + 1'b1;
            end
            if (cmd.put_new) begin
                occ_reg[p_reg] <= 1'b1;
                count_reg      <= count_reg + 1'b1;
            end
            if (cmd.erase_at_p) begin
                occ_reg[p_reg] <= 1'b0;
                count_reg      <= count_reg - 1'b1;
            end
            if (cmd.cl_load) begin
                occ_reg[cs_reg] <= 1'b0;
                count_reg       <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/lphash_ctrl.sv =====
// controller: sequences hashing, probing and cluster repair
`default_nettype none
module lphash_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire lphash_pkg::dp_stat_t stat,
    output lphash_pkg::dp_cmd_t       cmd
);
    import lphash_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_H0     = 10'b00_0000_0010,
        S_H1     = 10'b00_0000_0100,
        S_H2     = 10'b00_0000_1000,
        S_RD     = 10'b00_0001_0000,
        S_CHK    = 10'b00_0010_0000,
        S_CL_CHK = 10'b00_0100_0000,
        S_CL_RD  = 10'b00_1000_0000,
        S_CL_LD  = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   rein_reg, rein_next;
    logic   m_valid_reg, m_valid_next;
    logic   is_put;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign is_put  = rein_reg || (stat.mode == MODE_INSERT);

    always_comb begin
        state_next   = state_reg;
        rein_next    = rein_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.res_status = ST_NOT_FOUND;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    rein_next  = 1'b0;
                    state_next = S_H0;
                end
            end
            S_H0: begin
                cmd.hash0  = 1'b1;
                state_next = (stat.mode == MODE_NONE && !rein_reg) ? S_DONE : S_H1;
            end
            S_H1: begin
                cmd.hash1  = 1'b1;
                state_next = S_H2;
            end
            S_H2: begin
                cmd.hash2  = 1'b1;
                state_next = S_RD;
            end
            S_RD: begin
                state_next = S_CHK;
            end
            S_CHK: begin
                if (is_put) begin
                    cmd.coll_inc = stat.first && stat.occ_p && !stat.key_eq;
                    if (stat.occ_p && stat.key_eq) begin
                        cmd.put_upd    = 1'b1;
                        cmd.res_wr     = !rein_reg;
                        cmd.res_status = ST_UPDATED;
                        cmd.res_slot   = 1'b1;
                        cmd.cl_adv     = rein_reg;
                        state_next     = rein_reg ? S_CL_CHK : S_DONE;
                    end else if (!stat.occ_p) begin
                        cmd.put_new    = 1'b1;
                        cmd.res_wr     = !rein_reg;
                        cmd.res_status = ST_NEW;
                        cmd.res_slot   = 1'b1;
                        cmd.cl_adv     = rein_reg;
                        state_next     = rein_reg ? S_CL_CHK : S_DONE;
                    end else if (stat.n_last) begin
                        cmd.res_wr     = !rein_reg;
                        cmd.res_status = ST_FULL;
                        cmd.cl_adv     = rein_reg;
                        state_next     = rein_reg ? S_CL_CHK : S_DONE;
                    end else begin
                        cmd.adv    = 1'b1;
                        state_next = S_RD;
                    end
                end else begin
                    if (!stat.occ_p) begin
                        state_next = S_DONE;
                    end else if (stat.key_eq) begin
                        cmd.res_wr   = 1'b1;
                        cmd.res_slot = 1'b1;
                        if (stat.mode == MODE_FIND) begin
                            cmd.res_status = ST_FOUND;
                            cmd.res_val    = 1'b1;
                            state_next     = S_DONE;
                        end else begin
                            cmd.res_status = ST_ERASED;
                            cmd.erase_at_p = 1'b1;
                            state_next     = S_CL_CHK;
                        end
                    end else if (stat.n_last) begin
                        state_next = S_DONE;
                    end else begin
                        cmd.adv    = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_CL_CHK: begin
                state_next = (stat.cn_last || !stat.occ_cs) ? S_DONE : S_CL_RD;
            end
            S_CL_RD: begin
                cmd.cl_addr = 1'b1;
                state_next  = S_CL_LD;
            end
            S_CL_LD: begin
                cmd.cl_load = 1'b1;
                rein_next   = 1'b1;
                state_next  = S_H0;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rein_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rein_reg    <= rein_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/linear_probe_hash_table.sv =====
// top level of the linear probing key/value table
//
// s_ channel: one request transaction (mode, key, value); m_ channel: one
// result transaction (status, slot, value_out, count, collisions) per request
// 128 slots of 32-bit key and value in one table ram, occupancy in flip-flops
// the key mix is two 32x32 multiply rounds and a final fold; each probe reads
// the table ram, whose read is registered, before the entry is checked
// erase: as find, then each trailing cluster entry is lifted out and reinserted,
// and the cluster walk ends at a free slot or when the whole table has been walked
// unused mode 3: status not found
// one request is in flight at a time; s_ready is high only when idle
// the result register holds while m_ready is low; the next request is still
// accepted, and its result waits until the held result is taken
// reset (aresetn low, synchronous) empties the table at once: occupancy,
// entry count and collision count clear, no clearing pass needed
`default_nettype none
module linear_probe_hash_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_mode,
    input  wire logic [31:0] s_key,
    input  wire logic [31:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [6:0]       m_slot,
    output logic [31:0]      m_value_out,
    output logic [7:0]       m_count,
    output logic [31:0]      m_collisions
);
    import lphash_pkg::*;

    dp_cmd_t  cmd;   // controller to datapath
    dp_stat_t stat;  // datapath flags back to the controller

    // sequencer for probing and cluster repair
    lphash_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // table storage, key mix and result registers
    lphash_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_mode       (s_mode),
        .s_key        (s_key),
        .s_value      (s_value),
        .m_status     (m_status),
        .m_slot       (m_slot),
        .m_value_out  (m_value_out),
        .m_count      (m_count),
        .m_collisions (m_collisions)
    );
endmodule
`default_nettype wire

// ===== hdl/lphash_checker.sv =====
// port level checks for the linear probing hash table, bound to the top level
`default_nettype none
module lphash_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_status,
    input wire logic [31:0] m_value_out,
    input wire logic [7:0]  m_count
);
    import lphash_pkg::*;

    // a held result stays presented
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // one request at a time: busy right after an accepted transaction
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // only a find returns a value
    a_vout: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_FOUND |-> m_value_out == '0)
        else $error("value reported without a find hit");

    // occupancy never exceeds the capacity
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_count <= 8'(CAPACITY))
        else $error("entry count beyond capacity");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind linear_probe_hash_table lphash_checker u_lphash_checker (.*);
`default_nettype wire
